// ===== hdl/hmbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hmbs_pkg
// Shared types and constants of the health monitor and blink sequencer.
// ----------------------------------------------------------------------------
package hmbs_pkg;

    // item kinds carried in tuser
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_RAISE = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLINKER_ENABLE   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BOOT_PATTERN     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OK_PATTERN       = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ERROR_PATTERN    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OVERLOAD_PATTERN = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OVERCURRENT_BIT  = 3'd5;

    localparam int unsigned PATTERN_BITS = 32;
    localparam int unsigned ERR_IDX_BITS = 5;
    localparam int unsigned MODE_BITS    = 2;

    // card debounce counter
    typedef logic signed [3:0] card_cnt_t;
    localparam card_cnt_t CARD_START_PRESENT = 4'sd5;
    localparam card_cnt_t CARD_START_ABSENT  = -4'sd5;
    localparam card_cnt_t CARD_MAX           = 4'sd5;
    localparam card_cnt_t CARD_MIN           = -4'sd2;
    localparam card_cnt_t CARD_MOUNT         = 4'sd4;
    localparam card_cnt_t CARD_UNMOUNT       = -4'sd1;
    localparam card_cnt_t CARD_ZERO          = 4'sd0;
    localparam card_cnt_t CARD_ONE           = 4'sd1;

endpackage

// ===== hdl/health_monitor_blink_sequencer.sv =====
// ----------------------------------------------------------------------------
// health_monitor_blink_sequencer
// System health monitor with two-LED blink pattern sequencer.
// ----------------------------------------------------------------------------
// Every input word yields exactly one result word. A tick word (tuser = 0)
// checks the overcurrent pin; with the blinker enabled it drives both LEDs
// from the bit pair of the current blink pattern at the present index and
// steps the index by two (at wrap the ok pattern is loaded unless a raised
// error asked to repeat), tracks the last, smallest and largest supply
// sample, and debounces the card switch into mount, start-from-card and
// stop/unmount events. Command words load a pattern (1), raise an error
// bit (2) or clear all errors (3). The block takes one word per clock while
// results drain; an input register feeds single-pass update logic whose
// answer lands in the result register. While a result waits on m_tready,
// one more word still enters the input register; after that s_tready stays
// low until the result leaves. Configuration writes (cfg_we/cfg_index/
// cfg_wdata) take effect at once and are meant for idle periods; writing the
// boot pattern before the first tick also reloads the live pattern.
// ----------------------------------------------------------------------------
module health_monitor_blink_sequencer #(
    parameter int unsigned SAMPLE_BITS = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [hmbs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [hmbs_pkg::PATTERN_BITS-1:0]   cfg_wdata,
    // input words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pattern_word, error_code, adc_sample, overcurrent_n, card_switch,
    // mount_ok, zero fill
    input  logic [((hmbs_pkg::PATTERN_BITS + hmbs_pkg::ERR_IDX_BITS
                    + SAMPLE_BITS + 3 + 7) / 8) * 8 - 1:0] s_tdata,
    // mode
    input  logic [hmbs_pkg::MODE_BITS-1:0]      s_tuser,
    // result words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // led_drive_valid, led_one, led_two, voltage_now, voltage_low,
    // voltage_high, error_bits, mount_attempt, start_from_card,
    // stop_and_unmount, zero fill
    output logic [((3 + 3 * SAMPLE_BITS + hmbs_pkg::PATTERN_BITS + 3 + 7) / 8) * 8 - 1:0]
                                                m_tdata
);

    // field totals and byte-rounded bus widths
    localparam int unsigned IN_FIELDS  = hmbs_pkg::PATTERN_BITS + hmbs_pkg::ERR_IDX_BITS
                                         + SAMPLE_BITS + 3;
    localparam int unsigned IN_BITS    = hmbs_pkg::MODE_BITS + IN_FIELDS;
    localparam int unsigned OUT_BITS   = 3 + 3 * SAMPLE_BITS + hmbs_pkg::PATTERN_BITS + 3;
    localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    logic                in_valid;
    logic [IN_BITS-1:0]  in_item;
    logic                out_ready;
    logic [OUT_BITS-1:0] core_result;
    logic [OUT_BITS-1:0] out_data;

    // input register: mode rides in the low bits next to the tdata fields
    hmbs_reg_slice #(
        .W (IN_BITS)
    ) u_in_slice (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_data  ({s_tdata[IN_FIELDS-1:0], s_tuser}),
        .m_valid (in_valid),
        .m_ready (out_ready),
        .m_data  (in_item)
    );

    // state update happens as the word moves into the result register
    hmbs_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .IN_BITS     (IN_BITS),
        .OUT_BITS    (OUT_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item_fire (in_valid && out_ready),
        .item      (in_item),
        .result    (core_result)
    );

    // result register
    hmbs_reg_slice #(
        .W (OUT_BITS)
    ) u_out_slice (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (in_valid),
        .s_ready (out_ready),
        .s_data  (core_result),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (out_data)
    );

    assign m_tdata = OUT_TDATA_W'(out_data);

endmodule

// ===== hdl/hmbs_reg_slice.sv =====
// ----------------------------------------------------------------------------
// hmbs_reg_slice
// One-word pipeline register with valid/ready handshake, full rate.
// ----------------------------------------------------------------------------
module hmbs_reg_slice #(
    parameter int unsigned W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [W-1:0] s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [W-1:0] m_data
);

    logic         valid_reg;
    logic [W-1:0] data_reg;

    // take a new word when empty or when the held one leaves
    assign s_ready = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

// ===== hdl/hmbs_core.sv =====
// ----------------------------------------------------------------------------
// hmbs_core
// Monitor state, configuration registers and per-word update logic.
// ----------------------------------------------------------------------------
module hmbs_core #(
    parameter int unsigned SAMPLE_BITS = 12,
    parameter int unsigned IN_BITS     = 54,
    parameter int unsigned OUT_BITS    = 74
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [hmbs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [hmbs_pkg::PATTERN_BITS-1:0]   cfg_wdata,
    input  logic                                item_fire,
    input  logic [IN_BITS-1:0]                  item,
    output logic [OUT_BITS-1:0]                 result
);

    localparam int unsigned PB  = hmbs_pkg::PATTERN_BITS;
    localparam int unsigned EB  = hmbs_pkg::ERR_IDX_BITS;
    localparam int unsigned MB  = hmbs_pkg::MODE_BITS;
    localparam int unsigned SMP = MB + PB + EB;

    // unpacked item
    hmbs_pkg::mode_t        mode;
    logic [PB-1:0]          pword;
    logic [EB-1:0]          ecode;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   oc_n;
    logic                   card_sw;
    logic                   mok;

    assign mode    = hmbs_pkg::mode_t'(item[MB-1:0]);
    assign pword   = item[MB +: PB];
    assign ecode   = item[MB+PB +: EB];
    assign sample  = item[SMP +: SAMPLE_BITS];
    assign oc_n    = item[SMP+SAMPLE_BITS];
    assign card_sw = item[SMP+SAMPLE_BITS+1];
    assign mok     = item[SMP+SAMPLE_BITS+2];

    // configuration
    logic          enable_reg;
    logic [PB-1:0] ok_reg;
    logic [PB-1:0] errpat_reg;
    logic [PB-1:0] ovl_reg;
    logic [EB-1:0] ocbit_reg;

    // state
    logic [PB-1:0]          blink_reg, blink_next;
    logic [EB-1:0]          pos_reg, pos_next;
    logic                   repeat_reg, repeat_next;
    logic [PB-1:0]          err_reg, err_next;
    logic [SAMPLE_BITS-1:0] last_reg, last_next;
    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    hmbs_pkg::card_cnt_t    cnt_reg, cnt_next;
    logic                   primed_reg, primed_next;

    // per-word temporaries
    logic                drive, led1, led2, mnt, start, unmnt;
    logic [PB-1:0]       blink_eff;
    logic                repeat_eff;
    logic [EB:0]         pos_sum;
    hmbs_pkg::card_cnt_t cnt_base, cnt_step;

    always_comb begin
        blink_next  = blink_reg;
        pos_next    = pos_reg;
        repeat_next = repeat_reg;
        err_next    = err_reg;
        last_next   = last_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        cnt_next    = cnt_reg;
        primed_next = primed_reg;
        drive       = 1'b0;
        led1        = 1'b0;
        led2        = 1'b0;
        mnt         = 1'b0;
        start       = 1'b0;
        unmnt       = 1'b0;
        blink_eff   = blink_reg;
        repeat_eff  = repeat_reg;
        pos_sum     = {1'b0, pos_reg} + (EB+1)'(2);
        cnt_base    = cnt_reg;
        cnt_step    = cnt_reg;

        case (mode)
            hmbs_pkg::MODE_LOAD: begin
                blink_next = pword;
                pos_next   = '0;
            end
            hmbs_pkg::MODE_RAISE: begin
                err_next    = err_reg | (PB'(1) << ecode);
                repeat_next = 1'b1;
                blink_next  = errpat_reg;
                pos_next    = '0;
            end
            hmbs_pkg::MODE_CLEAR: begin
                err_next = '0;
            end
            hmbs_pkg::MODE_TICK: begin
                // first tick seeds the debounce counter
                if (!primed_reg) begin
                    cnt_base = card_sw ? hmbs_pkg::CARD_START_ABSENT
                                       : hmbs_pkg::CARD_START_PRESENT;
                end
                primed_next = 1'b1;

                // overcurrent: flag error, switch to overload pattern
                if (!oc_n) begin
                    err_next   = err_reg | (PB'(1) << ocbit_reg);
                    blink_eff  = ovl_reg;
                    repeat_eff = 1'b0;
                    pos_next   = '0;
                end
                blink_next  = blink_eff;
                repeat_next = repeat_eff;

                // LED pair from the index held at step start
                if (enable_reg) begin
                    drive = 1'b1;
                    led1  = blink_eff[pos_reg];
                    led2  = (pos_reg == EB'(PB-1)) ? 1'b0
                                                   : blink_eff[pos_reg + EB'(1)];
                    if (pos_sum[EB]) begin
                        if (!repeat_eff) begin
                            blink_next = ok_reg;
                        end
                        pos_next = '0;
                    end else begin
                        pos_next = pos_sum[EB-1:0];
                    end
                end

                // supply tracking
                if (sample > max_reg) begin
                    max_next = sample;
                end
                if (sample < min_reg) begin
                    min_next = sample;
                end
                last_next = sample;

                // card debounce
                if (!card_sw) begin
                    cnt_step = cnt_base + hmbs_pkg::CARD_ONE;
                    if (cnt_step < hmbs_pkg::CARD_ZERO) begin
                        cnt_step = hmbs_pkg::CARD_ZERO;
                    end
                    if (cnt_step > hmbs_pkg::CARD_MAX) begin
                        cnt_step = hmbs_pkg::CARD_MAX;
                    end
                    if (cnt_step == hmbs_pkg::CARD_MOUNT) begin
                        mnt = 1'b1;
                        if (mok) begin
                            start = 1'b1;
                        end else begin
                            pos_next   = '0;
                            blink_next = ovl_reg;
                        end
                    end
                end else begin
                    cnt_step = cnt_base - hmbs_pkg::CARD_ONE;
                    if (cnt_step > hmbs_pkg::CARD_ZERO) begin
                        cnt_step = hmbs_pkg::CARD_ZERO;
                    end
                    if (cnt_step < hmbs_pkg::CARD_MIN) begin
                        cnt_step = hmbs_pkg::CARD_MIN;
                    end
                    if (cnt_step == hmbs_pkg::CARD_UNMOUNT) begin
                        unmnt = 1'b1;
                    end
                end
                cnt_next = cnt_step;
            end
            default: begin
            end
        endcase
    end

    // result layout, high bit first
    assign result = {unmnt, start, mnt, err_next, max_next, min_next, last_next,
                     led2, led1, drive};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
            ok_reg     <= '0;
            errpat_reg <= '0;
            ovl_reg    <= '0;
            ocbit_reg  <= '0;
            blink_reg  <= '0;
            pos_reg    <= '0;
            repeat_reg <= 1'b0;
            err_reg    <= '0;
            last_reg   <= '0;
            min_reg    <= '1;
            max_reg    <= '0;
            cnt_reg    <= hmbs_pkg::CARD_ZERO;
            primed_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                hmbs_pkg::CFG_BLINKER_ENABLE:   enable_reg <= cfg_wdata[0];
                hmbs_pkg::CFG_BOOT_PATTERN: begin
                    // boot pattern only matters until the first tick
                    if (!primed_reg) begin
                        blink_reg <= cfg_wdata;
                        pos_reg   <= '0;
                    end
                end
                hmbs_pkg::CFG_OK_PATTERN:       ok_reg     <= cfg_wdata;
                hmbs_pkg::CFG_ERROR_PATTERN:    errpat_reg <= cfg_wdata;
                hmbs_pkg::CFG_OVERLOAD_PATTERN: ovl_reg    <= cfg_wdata;
                hmbs_pkg::CFG_OVERCURRENT_BIT:  ocbit_reg  <= cfg_wdata[EB-1:0];
                default: begin
                end
            endcase
        end else if (item_fire) begin
            blink_reg  <= blink_next;
            pos_reg    <= pos_next;
            repeat_reg <= repeat_next;
            err_reg    <= err_next;
            last_reg   <= last_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            cnt_reg    <= cnt_next;
            primed_reg <= primed_next;
        end
    end

    // index only ever moves in steps of two from zero
    a_pos_even: assert property (@(posedge aclk) disable iff (!aresetn)
        !pos_reg[0])
        else $error("blink index went odd");

    // debounce counter sits in its saturation window once seeded
    a_cnt_window: assert property (@(posedge aclk) disable iff (!aresetn)
        primed_reg |-> (cnt_reg >= hmbs_pkg::CARD_MIN && cnt_reg <= hmbs_pkg::CARD_MAX))
        else $error("card counter out of range");

    // mount and unmount events exclude each other; start needs a mount
    a_events: assert property (@(posedge aclk) disable iff (!aresetn)
        item_fire |-> (!(mnt && unmnt) && (!start || mnt)))
        else $error("conflicting card events");

    // after any tick, min never exceeds max
    a_minmax: assert property (@(posedge aclk) disable iff (!aresetn)
        primed_reg |-> (min_reg <= max_reg))
        else $error("supply min above max");

    // a tick not blocked by a configuration write arms the debounce logic
    a_primed: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_fire && !cfg_we && mode == hmbs_pkg::MODE_TICK) |=> primed_reg)
        else $error("tick left block unprimed");

endmodule
